/* src/stpe_pkg.sv */
// Shared types and constants for the symbolic tag path encoder.
// Used by stpe_front, stpe_cmd_fifo, stpe_back and the top level; no dependencies.
package stpe_pkg;

  // Width of a name length (holds name lengths of up to 63 characters)
  localparam int unsigned NameLenW = 6;

  // Segment codes and fixed path bytes
  localparam logic [7:0] SegTagName = 8'h91;
  localparam logic [7:0] SegIdx8    = 8'h28;
  localparam logic [7:0] SegIdx16   = 8'h29;
  localparam logic [7:0] SegIdx32   = 8'h2A;

  // Result kinds
  localparam logic [1:0] KindByte   = 2'd0;
  localparam logic [1:0] KindDone   = 2'd1;
  localparam logic [1:0] KindReject = 2'd2;

  // Command queue depth
  localparam int unsigned CmdDepth = 2;

  typedef enum logic [1:0] {
    MODE_NAME_START,
    MODE_IN_NAME,
    MODE_IN_INDEX,
    MODE_AFTER_INDEX
  } mode_e;

  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_NAME,
    SEG_INDEX
  } seg_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR,
    B_LEN,
    B_CHR,
    B_PAD,
    B_IDX,
    B_END
  } back_state_e;

  // One unit of work for the back end: at most one segment, then maybe the end result
  typedef struct packed {
    seg_e                seg;
    logic [NameLenW-1:0] name_len;
    logic [31:0]         idx_val;
    logic [2:0]          idx_bytes;
    logic                has_end;
    logic                end_ok;
    logic [6:0]          words;
  } cmd_t;

  // Name store write from the front end
  typedef struct packed {
    logic                en;
    logic [NameLenW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

/* src/symbolic_tag_path_encoder_unit.sv */
// Top level of the symbolic tag path encoder: front end, command queue, back end.
// Depends on stpe_pkg, stpe_front, stpe_cmd_fifo and stpe_back.
//
//   channel   direction  handshake                         payload
//   tag_char  in         tag_char_valid_i / _stall_o       tag_char_i
//   result    out        result_valid_o / result_stall_i   path_byte_o kind_o path_words_o last_o
//   config    in         cfg_we_i                          cfg_data_i (path_capacity)
//
// The front takes one character per cycle while it does not stall; each one that causes results queues one command.
// The back takes a command while idle, then loads one result item at a time: 2 + len + pad
// items for a name, 2, 4 or 6 for an index, plus one for the end result.
// A name character waits at the front until the queue is empty and the back is idle.
// Reset is asynchronous, active low; the name store needs no clearing.
// A stalled result holds in the output register; the queue keeps the front running until it fills.
module symbolic_tag_path_encoder_unit #(
  parameter int unsigned MAX_NAME_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       tag_char_valid_i,
  output logic       tag_char_stall_o,
  input  logic [7:0] tag_char_i,
  output logic       result_valid_o,
  input  logic       result_stall_i,
  output logic [7:0] path_byte_o,
  output logic [1:0] kind_o,
  output logic [6:0] path_words_o,
  output logic       last_o
);

  stpe_pkg::cmd_t      push_cmd, head_cmd;
  stpe_pkg::store_wr_t store_wr;
  logic push, pop, fifo_empty, fifo_full, back_busy;

  stpe_front #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .tag_char_valid_i (tag_char_valid_i),
    .tag_char_stall_o (tag_char_stall_o),
    .tag_char_i       (tag_char_i),
    .fifo_full_i      (fifo_full),
    .back_busy_i      (back_busy),
    .push_o           (push),
    .cmd_o            (push_cmd),
    .store_wr_o       (store_wr)
  );

  stpe_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  stpe_back #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .store_wr_i     (store_wr),
    .head_i         (head_cmd),
    .empty_i        (fifo_empty),
    .pop_o          (pop),
    .busy_o         (back_busy),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .path_byte_o    (path_byte_o),
    .kind_o         (kind_o),
    .path_words_o   (path_words_o),
    .last_o         (last_o)
  );

endmodule

/* src/stpe_front.sv */
// Front end: parses tag characters, tracks path bytes against capacity, queues commands.
// Depends on stpe_pkg.
module stpe_front #(
  parameter int unsigned MAX_NAME_CHARS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               tag_char_valid_i,
  output logic               tag_char_stall_o,
  input  logic [7:0]         tag_char_i,
  input  logic               fifo_full_i,
  input  logic               back_busy_i,
  output logic               push_o,
  output stpe_pkg::cmd_t     cmd_o,
  output stpe_pkg::store_wr_t store_wr_o
);

  stpe_pkg::mode_e                 mode_q, mode_d;
  logic [stpe_pkg::NameLenW-1:0]   name_len_q, name_len_d;
  logic [31:0]                     idx_val_q, idx_val_d;
  logic                            has_digit_q, has_digit_d;
  logic [7:0]                      bytes_q, bytes_d;
  logic                            rejected_q, rejected_d;
  logic [7:0]                      cap_q;

  logic        is_end, is_dot, is_open, is_close, is_digit;
  logic [8:0]  name_seg, name_sum, idx_sum;
  logic        name_fits, idx_fits;
  logic [2:0]  idx_n;
  logic [31:0] idx_next;
  logic [7:0]  bytes_nx;
  logic        rej_nx;
  logic        accept;
  stpe_pkg::store_wr_t store_req;

  assign is_end   = (tag_char_i == 8'h00);
  assign is_dot   = (tag_char_i == 8'h2E);
  assign is_open  = (tag_char_i == 8'h5B);
  assign is_close = (tag_char_i == 8'h5D);
  assign is_digit = (tag_char_i >= 8'h30) && (tag_char_i <= 8'h39);

  // Segment sizes and capacity checks
  assign name_seg  = 9'd2 + 9'(name_len_q) + 9'(name_len_q[0]);
  assign name_sum  = {1'b0, bytes_q} + name_seg;
  assign name_fits = (name_sum <= {1'b0, cap_q});
  assign idx_n     = (|idx_val_q[31:16]) ? 3'd6 : ((|idx_val_q[15:8]) ? 3'd4 : 3'd2);
  assign idx_sum   = {1'b0, bytes_q} + 9'(idx_n);
  assign idx_fits  = (idx_sum <= {1'b0, cap_q});
  assign idx_next  = {idx_val_q[28:0], 3'b000} + {idx_val_q[30:0], 1'b0}
                   + {28'd0, tag_char_i[3:0]};

  // Parse one character
  always_comb begin
    mode_d        = mode_q;
    name_len_d    = name_len_q;
    idx_val_d     = idx_val_q;
    has_digit_d   = has_digit_q;
    bytes_nx      = bytes_q;
    rej_nx        = rejected_q;
    cmd_o         = '0;
    cmd_o.seg     = stpe_pkg::SEG_NONE;
    store_req     = '0;
    if (!rejected_q) begin
      case (mode_q)
        stpe_pkg::MODE_IN_NAME: begin
          if (is_end || is_dot || is_open) begin
            if (name_fits) begin
              cmd_o.seg      = stpe_pkg::SEG_NAME;
              cmd_o.name_len = name_len_q;
              bytes_nx       = name_sum[7:0];
              name_len_d     = '0;
              mode_d         = is_open ? stpe_pkg::MODE_IN_INDEX : stpe_pkg::MODE_NAME_START;
              idx_val_d      = '0;
              has_digit_d    = 1'b0;
            end else begin
              rej_nx = 1'b1;
            end
          end else if (name_len_q >= stpe_pkg::NameLenW'(MAX_NAME_CHARS)) begin
            rej_nx = 1'b1;
          end else begin
            store_req.en   = 1'b1;
            store_req.addr = name_len_q;
            store_req.data = tag_char_i;
            name_len_d     = name_len_q + 1'b1;
          end
        end
        stpe_pkg::MODE_IN_INDEX: begin
          if (is_digit) begin
            idx_val_d   = idx_next;
            has_digit_d = 1'b1;
          end else if (is_close && has_digit_q) begin
            if (idx_fits) begin
              cmd_o.seg       = stpe_pkg::SEG_INDEX;
              cmd_o.idx_val   = idx_val_q;
              cmd_o.idx_bytes = idx_n;
              bytes_nx        = idx_sum[7:0];
            end else begin
              rej_nx = 1'b1;
            end
            mode_d = stpe_pkg::MODE_AFTER_INDEX;
          end else begin
            rej_nx = 1'b1;
          end
        end
        stpe_pkg::MODE_AFTER_INDEX: begin
          if (is_open) begin
            mode_d      = stpe_pkg::MODE_IN_INDEX;
            idx_val_d   = '0;
            has_digit_d = 1'b0;
          end else if (is_dot) begin
            mode_d = stpe_pkg::MODE_NAME_START;
          end else if (!is_end) begin
            store_req.en   = 1'b1;
            store_req.addr = '0;
            store_req.data = tag_char_i;
            name_len_d     = stpe_pkg::NameLenW'(1);
            mode_d         = stpe_pkg::MODE_IN_NAME;
          end
        end
        default: begin
          if (is_end) begin
            if (bytes_q == 8'd0) rej_nx = 1'b1;
          end else if (is_dot || is_open) begin
            rej_nx = 1'b1;
          end else begin
            store_req.en   = 1'b1;
            store_req.addr = '0;
            store_req.data = tag_char_i;
            name_len_d     = stpe_pkg::NameLenW'(1);
            mode_d         = stpe_pkg::MODE_IN_NAME;
          end
        end
      endcase
    end
    bytes_d    = bytes_nx;
    rejected_d = rej_nx;
    // End of tag: report and clear per-tag state
    if (is_end) begin
      cmd_o.has_end = 1'b1;
      cmd_o.end_ok  = !rej_nx;
      cmd_o.words   = bytes_nx[7:1];
      mode_d        = stpe_pkg::MODE_NAME_START;
      name_len_d    = '0;
      idx_val_d     = '0;
      has_digit_d   = 1'b0;
      bytes_d       = '0;
      rejected_d    = 1'b0;
    end
  end

  // Hold the character while its command finds the queue full, or while it writes the store and the back end is busy
  assign push_o           = accept && ((cmd_o.seg != stpe_pkg::SEG_NONE) || cmd_o.has_end);
  assign tag_char_stall_o = (((cmd_o.seg != stpe_pkg::SEG_NONE) || cmd_o.has_end)
                             && fifo_full_i) || (store_req.en && back_busy_i);
  assign accept           = tag_char_valid_i && !tag_char_stall_o;

  // Write the name store only on a transfer
  assign store_wr_o = '{en: store_req.en && accept, addr: store_req.addr,
                        data: store_req.data};

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= stpe_pkg::MODE_NAME_START;
      name_len_q  <= '0;
      idx_val_q   <= '0;
      has_digit_q <= 1'b0;
      bytes_q     <= '0;
      rejected_q  <= 1'b0;
    end else if (accept) begin
      mode_q      <= mode_d;
      name_len_q  <= name_len_d;
      idx_val_q   <= idx_val_d;
      has_digit_q <= has_digit_d;
      bytes_q     <= bytes_d;
      rejected_q  <= rejected_d;
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 8'd80;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

endmodule

/* src/stpe_cmd_fifo.sv */
// Short command queue between the front and back ends.
// Depends on stpe_pkg for the command type and depth.
module stpe_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  stpe_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output stpe_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PtrW = $clog2(stpe_pkg::CmdDepth);

  stpe_pkg::cmd_t entries_q [stpe_pkg::CmdDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PtrW+1)'(stpe_pkg::CmdDepth));
  assign head_o  = entries_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

endmodule

/* src/stpe_back.sv */
// Back end: owns the name store and sequences path bytes and end results to the output register.
// Depends on stpe_pkg.
module stpe_back #(
  parameter int unsigned MAX_NAME_CHARS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stpe_pkg::store_wr_t store_wr_i,
  input  stpe_pkg::cmd_t      head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                busy_o,
  output logic                result_valid_o,
  input  logic                result_stall_i,
  output logic [7:0]          path_byte_o,
  output logic [1:0]          kind_o,
  output logic [6:0]          path_words_o,
  output logic                last_o
);

  localparam int unsigned AddrW = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;

  logic [7:0] store_mem [MAX_NAME_CHARS];
  logic [7:0] rd_data_q;

  stpe_pkg::back_state_e         st_q, st_d;
  stpe_pkg::cmd_t                cmd_q, cmd_d;
  logic [AddrW-1:0]              idx_q, idx_d;
  logic [2:0]                    k_q, k_d;
  logic [stpe_pkg::NameLenW-1:0] idx_ext;

  logic       can_load, load;
  logic [7:0] byte_d;
  logic [1:0] kind_d;
  logic [6:0] words_d;
  logic       last_d;
  logic       out_valid_q;

  assign can_load = !out_valid_q || !result_stall_i;
  assign idx_ext  = stpe_pkg::NameLenW'(idx_q);
  assign busy_o   = !empty_i || (st_q != stpe_pkg::B_IDLE);

  // Name store: one write port, one registered read at the next character address
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) store_mem[store_wr_i.addr[AddrW-1:0]] <= store_wr_i.data;
    rd_data_q <= store_mem[idx_d];
  end

  // Sequence one command into output items
  always_comb begin
    st_d    = st_q;
    cmd_d   = cmd_q;
    idx_d   = idx_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    byte_d  = 8'h00;
    kind_d  = stpe_pkg::KindByte;
    words_d = 7'd0;
    last_d  = 1'b0;
    case (st_q)
      stpe_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          idx_d = '0;
          k_d   = '0;
          case (head_i.seg)
            stpe_pkg::SEG_NAME:  st_d = stpe_pkg::B_HDR;
            stpe_pkg::SEG_INDEX: st_d = stpe_pkg::B_IDX;
            default:             st_d = stpe_pkg::B_END;
          endcase
        end
      end
      stpe_pkg::B_HDR: begin
        byte_d = stpe_pkg::SegTagName;
        if (can_load) begin
          load = 1'b1;
          st_d = stpe_pkg::B_LEN;
        end
      end
      stpe_pkg::B_LEN: begin
        byte_d = 8'(cmd_q.name_len);
        if (can_load) begin
          load = 1'b1;
          st_d = stpe_pkg::B_CHR;
        end
      end
      stpe_pkg::B_CHR: begin
        byte_d = rd_data_q;
        if (idx_ext == cmd_q.name_len - 1'b1) begin
          last_d = !cmd_q.name_len[0] && !cmd_q.has_end;
          if (can_load) begin
            load = 1'b1;
            if (cmd_q.name_len[0]) st_d = stpe_pkg::B_PAD;
            else st_d = cmd_q.has_end ? stpe_pkg::B_END : stpe_pkg::B_IDLE;
          end
        end else if (can_load) begin
          load  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
      stpe_pkg::B_PAD: begin
        byte_d = 8'h00;
        last_d = !cmd_q.has_end;
        if (can_load) begin
          load = 1'b1;
          st_d = cmd_q.has_end ? stpe_pkg::B_END : stpe_pkg::B_IDLE;
        end
      end
      stpe_pkg::B_IDX: begin
        // Little-endian index bytes after the segment code
        case (k_q)
          3'd0: begin
            if (cmd_q.idx_bytes == 3'd2)      byte_d = stpe_pkg::SegIdx8;
            else if (cmd_q.idx_bytes == 3'd4) byte_d = stpe_pkg::SegIdx16;
            else                              byte_d = stpe_pkg::SegIdx32;
          end
          3'd1:    byte_d = (cmd_q.idx_bytes == 3'd2) ? cmd_q.idx_val[7:0] : 8'h00;
          3'd2:    byte_d = cmd_q.idx_val[7:0];
          3'd3:    byte_d = cmd_q.idx_val[15:8];
          3'd4:    byte_d = cmd_q.idx_val[23:16];
          3'd5:    byte_d = cmd_q.idx_val[31:24];
          default: byte_d = 8'h00;
        endcase
        if (k_q == cmd_q.idx_bytes - 1'b1) begin
          last_d = !cmd_q.has_end;
          if (can_load) begin
            load = 1'b1;
            st_d = cmd_q.has_end ? stpe_pkg::B_END : stpe_pkg::B_IDLE;
          end
        end else if (can_load) begin
          load = 1'b1;
          k_d  = k_q + 1'b1;
        end
      end
      stpe_pkg::B_END: begin
        kind_d  = cmd_q.end_ok ? stpe_pkg::KindDone : stpe_pkg::KindReject;
        words_d = cmd_q.end_ok ? cmd_q.words : 7'd0;
        last_d  = 1'b1;
        if (can_load) begin
          load = 1'b1;
          st_d = stpe_pkg::B_IDLE;
        end
      end
      default: st_d = stpe_pkg::B_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= stpe_pkg::B_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Command and counters
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    k_q   <= k_d;
  end

  // Output register: load a new item, drop it once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!result_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      path_byte_o  <= byte_d;
      kind_o       <= kind_d;
      path_words_o <= words_d;
      last_o       <= last_d;
    end
  end

  assign result_valid_o = out_valid_q;

endmodule
